[rtl/bpl_pkg.sv]
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared constants, action codes and word types of the buffer pool manager.
// ----------------------------------------------------------------------------
package bpl_pkg;

    // Pool geometry
    localparam int NODES      = 256;
    localparam int NODE_W     = $clog2(NODES);
    localparam int COUNT_W    = $clog2(NODES + 1);
    localparam int DATA_WIDTH = 32;
    localparam int ACTION_W   = 3;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Action codes; codes 6 and 7 do nothing
    typedef enum logic [ACTION_W-1:0] {
        ACT_TAKE_FREE = 3'd0,
        ACT_PUT_BUSY  = 3'd1,
        ACT_TAKE_BUSY = 3'd2,
        ACT_PUT_FREE  = 3'd3,
        ACT_PUSH      = 3'd4,
        ACT_POP       = 3'd5
    } action_t;

    // Command word
    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [NODE_W-1:0]     node_index;
        logic [DATA_WIDTH-1:0] payload_in;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic                  status;
        logic [NODE_W-1:0]     node_out;
        logic [DATA_WIDTH-1:0] payload_out;
        logic [COUNT_W-1:0]    free_total;
        logic [COUNT_W-1:0]    busy_total;
    } rsp_t;

    // Pool size load from the register block
    typedef struct packed {
        logic               load;
        logic [COUNT_W-1:0] size;
    } cfg_t;

    // Link memory access
    typedef struct packed {
        logic              clr;
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [NODE_W-1:0] wr_data;
    } link_req_t;

    // Payload memory access
    typedef struct packed {
        logic                  rd_en;
        logic [NODE_W-1:0]     rd_addr;
        logic                  wr_en;
        logic [NODE_W-1:0]     wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
    } pay_req_t;

endpackage

[rtl/bpl_data_ram.sv]
// ----------------------------------------------------------------------------
// bpl_data_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpl_data_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/bpl_link_ram.sv]
// ----------------------------------------------------------------------------
// bpl_link_ram
// Next-link memory. A per-entry valid bit makes an unwritten entry read as
// the in-order chain (index plus one); a clear drops all valid bits at once.
// ----------------------------------------------------------------------------
module bpl_link_ram (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bpl_pkg::link_req_t       req,
    output logic [bpl_pkg::NODE_W-1:0] rd_data
);
    import bpl_pkg::*;

    logic [NODE_W-1:0] mem [NODES];
    logic [NODES-1:0]  valid_reg;
    logic [NODE_W-1:0] rd_mem_reg;
    logic [NODE_W-1:0] rd_addr_reg;
    logic              rd_vld_reg;

    // Link storage
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read data and the address it came from
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_mem_reg  <= mem[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    // Written marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // Unwritten entry reads as the next node in order (wraps at NODES)
    assign rd_data = rd_vld_reg ? rd_mem_reg : NODE_W'(rd_addr_reg + 1'b1);

endmodule

[rtl/bpl_apb_regs.sv]
// ----------------------------------------------------------------------------
// bpl_apb_regs
// APB register block holding pool_size; a write clamps the value and
// signals the list controller to rebuild the lists.
// ----------------------------------------------------------------------------
module bpl_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bpl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bpl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    output bpl_pkg::cfg_t                  cfg
);
    import bpl_pkg::*;

    localparam logic ADDR_POOL_SIZE = 1'b0;

    logic [COUNT_W-1:0] pool_size_reg;
    logic [COUNT_W-1:0] size_clamped;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == ADDR_POOL_SIZE);

    // Only the low COUNT_W bits count: zero counts as one, anything above the pool counts as the pool
    always_comb
    begin
        size_clamped = pwdata[COUNT_W-1:0];
        if (size_clamped == '0)
        begin
            size_clamped = COUNT_W'(1);
        end
        else if (size_clamped > COUNT_W'(NODES))
        begin
            size_clamped = COUNT_W'(NODES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= COUNT_W'(NODES);
        end
        else if (wr_hit)
        begin
            pool_size_reg <= size_clamped;
        end
    end

    // Read back
    assign prdata = (paddr[2] == ADDR_POOL_SIZE) ? CFG_DATA_W'(pool_size_reg) : '0;

    assign cfg.load = wr_hit;
    assign cfg.size = size_clamped;

endmodule

[rtl/bpl_list_ctrl.sv]
// ----------------------------------------------------------------------------
// bpl_list_ctrl
// Free and busy list registers and the two-step sequencer: read the head's
// link and payload, then update the lists and write back at most one link
// and one payload word.
// ----------------------------------------------------------------------------
module bpl_list_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bpl_pkg::cmd_t                 cmd,
    input  bpl_pkg::cfg_t                 cfg,
    output bpl_pkg::link_req_t            link_req,
    input  logic [bpl_pkg::NODE_W-1:0]    link_rd,
    output bpl_pkg::pay_req_t             pay_req,
    input  logic [bpl_pkg::DATA_WIDTH-1:0] pay_rd,
    output logic                          done,
    output bpl_pkg::rsp_t                 result
);
    import bpl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    rsp_t               result_reg, result_next;
    logic               done_reg;

    logic [NODE_W-1:0]  free_head_reg, free_head_next;
    logic [NODE_W-1:0]  free_tail_reg, free_tail_next;
    logic [COUNT_W-1:0] free_count_reg, free_count_next;
    logic [NODE_W-1:0]  busy_head_reg, busy_head_next;
    logic [NODE_W-1:0]  busy_tail_reg, busy_tail_next;
    logic [COUNT_W-1:0] busy_count_reg, busy_count_next;

    logic               accept;
    logic               exec;
    logic               take_free, take_busy;
    logic               free_ok, busy_ok;
    logic               empty;
    logic               put_free, put_busy;
    logic               free_link, busy_link;
    logic [NODE_W-1:0]  put_free_node, put_busy_node;

    assign exec   = (state_reg == ST_EXEC);
    assign busy   = exec;
    assign accept = start && (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Action decode in the update step
    always_comb
    begin
        take_free = exec && (cmd_reg.action == ACT_TAKE_FREE || cmd_reg.action == ACT_PUSH);
        take_busy = exec && (cmd_reg.action == ACT_TAKE_BUSY || cmd_reg.action == ACT_POP);
        free_ok   = take_free && (free_count_reg != '0);
        busy_ok   = take_busy && (busy_count_reg != '0);
        empty     = (take_free && !free_ok) || (take_busy && !busy_ok);

        put_free      = (exec && cmd_reg.action == ACT_PUT_FREE)
                     || (busy_ok && cmd_reg.action == ACT_POP);
        put_free_node = (cmd_reg.action == ACT_POP) ? busy_head_reg : cmd_reg.node_index;
        put_busy      = (exec && cmd_reg.action == ACT_PUT_BUSY)
                     || (free_ok && cmd_reg.action == ACT_PUSH);
        put_busy_node = (cmd_reg.action == ACT_PUSH) ? free_head_reg : cmd_reg.node_index;

        // A full list drops the put
        free_link = put_free && (free_count_reg != COUNT_W'(NODES));
        busy_link = put_busy && (busy_count_reg != COUNT_W'(NODES));
    end

    // Memory requests and list updates
    always_comb
    begin
        // Reads issued on accept: link of the head to be taken, busy payload
        pay_req.rd_en    = accept;
        pay_req.rd_addr  = busy_head_reg;
        link_req.clr     = cfg.load;
        link_req.rd_en   = accept;
        link_req.rd_addr = (cmd.action == ACT_TAKE_FREE || cmd.action == ACT_PUSH)
                         ? free_head_reg : busy_head_reg;

        free_head_next  = free_head_reg;
        free_tail_next  = free_tail_reg;
        free_count_next = free_count_reg;
        busy_head_next  = busy_head_reg;
        busy_tail_next  = busy_tail_reg;
        busy_count_next = busy_count_reg;

        // Take from the head
        if (free_ok)
        begin
            if (free_count_reg > COUNT_W'(1))
            begin
                free_head_next = link_rd;
            end
            free_count_next = free_count_reg - 1'b1;
        end
        if (busy_ok)
        begin
            if (busy_count_reg > COUNT_W'(1))
            begin
                busy_head_next = link_rd;
            end
            busy_count_next = busy_count_reg - 1'b1;
        end

        // Append at the tail
        if (free_link)
        begin
            if (free_count_reg == '0)
            begin
                free_head_next = put_free_node;
            end
            free_tail_next  = put_free_node;
            free_count_next = free_count_reg + 1'b1;
        end
        if (busy_link)
        begin
            if (busy_count_reg == '0)
            begin
                busy_head_next = put_busy_node;
            end
            busy_tail_next  = put_busy_node;
            busy_count_next = busy_count_reg + 1'b1;
        end

        // At most one link write: the two puts never meet in one action
        link_req.wr_en   = (free_link && free_count_reg != '0)
                        || (busy_link && busy_count_reg != '0);
        link_req.wr_addr = free_link ? free_tail_reg : busy_tail_reg;
        link_req.wr_data = free_link ? put_free_node : put_busy_node;

        pay_req.wr_en   = put_busy;
        pay_req.wr_addr = put_busy_node;
        pay_req.wr_data = cmd_reg.payload_in;

        // Result word
        result_next.status      = empty;
        result_next.node_out    = free_ok ? free_head_reg
                                : (busy_ok ? busy_head_reg : '0);
        result_next.payload_out = busy_ok ? pay_rd : '0;
        result_next.free_total  = free_count_next;
        result_next.busy_total  = busy_count_next;
    end

    // Control and list registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            done_reg       <= 1'b0;
            free_head_reg  <= '0;
            free_tail_reg  <= NODE_W'(NODES - 1);
            free_count_reg <= COUNT_W'(NODES);
            busy_head_reg  <= '0;
            busy_tail_reg  <= '0;
            busy_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            priority if (cfg.load)
            begin
                free_head_reg  <= '0;
                free_tail_reg  <= NODE_W'(cfg.size - 1'b1);
                free_count_reg <= cfg.size;
                busy_head_reg  <= '0;
                busy_tail_reg  <= '0;
                busy_count_reg <= '0;
            end
            else
            begin
                free_head_reg  <= free_head_next;
                free_tail_reg  <= free_tail_next;
                free_count_reg <= free_count_next;
                busy_head_reg  <= busy_head_next;
                busy_tail_reg  <= busy_tail_next;
                busy_count_reg <= busy_count_next;
            end
        end
    end

    // Command and result words
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // Each result follows exactly one update step
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> done)
        else $error("result strobe missing after update step");

    // Counts never exceed the pool
    a_free_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= COUNT_W'(NODES))
        else $error("free count out of range");

    a_busy_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_count_reg <= COUNT_W'(NODES))
        else $error("busy count out of range");

    // An empty take reports no node and no payload
    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status) |-> (result.node_out == '0 && result.payload_out == '0))
        else $error("empty status with node or payload");

    // A single action moves the free count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && !cfg.load) |=> ((free_count_reg == $past(free_count_reg))
            || (free_count_reg == $past(free_count_reg) + 1'b1)
            || (free_count_reg == $past(free_count_reg) - 1'b1)))
        else $error("free count jumped");
`endif

endmodule

[rtl/buffer_pool_free_busy_lists.sv]
// ----------------------------------------------------------------------------
// buffer_pool_free_busy_lists
// Buffer pool manager: nodes kept on free and busy linked FIFO lists in a
// shared next-link memory, with one payload word per node.
//
//   channel   handshake                  word
//   -------   ------------------------   ---------------------------------
//   command   start, busy                cmd (action, node_index, payload_in)
//   result    done (one-cycle strobe)    result (status, node, payload, totals)
//   config    APB psel/penable/pwrite    pool_size at byte address 0
//
// Each action reads on accept the head's link word and the busy head's payload
// word into the registered memory outputs; the update step (ST_EXEC) then
// updates the lists and writes back at most one link and one payload word.
// busy is high during the update cycle; done shows the result in the cycle
// after it, while the next command may already be accepted.
// Reset and a pool_size write rebuild the lists at once: link entries carry
// a valid bit, so no clearing pass is needed. The receiver cannot stall.
// ----------------------------------------------------------------------------
module buffer_pool_free_busy_lists (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bpl_pkg::cmd_t                  cmd,
    output logic                           done,
    output bpl_pkg::rsp_t                  result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpl_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bpl_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bpl_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bpl_pkg::*;

    cfg_t                  cfg;
    link_req_t             link_req;
    logic [NODE_W-1:0]     link_rd;
    pay_req_t              pay_req;
    logic [DATA_WIDTH-1:0] pay_rd;

    // Configuration register
    bpl_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Next-link memory
    bpl_link_ram u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rd)
    );

    // Payload memory
    bpl_data_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (NODES)
    ) u_payload (
        .clk     (clk),
        .wr_en   (pay_req.wr_en),
        .wr_addr (pay_req.wr_addr),
        .wr_data (pay_req.wr_data),
        .rd_en   (pay_req.rd_en),
        .rd_addr (pay_req.rd_addr),
        .rd_data (pay_rd)
    );

    // List controller
    bpl_list_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg      (cfg),
        .link_req (link_req),
        .link_rd  (link_rd),
        .pay_req  (pay_req),
        .pay_rd   (pay_rd),
        .done     (done),
        .result   (result)
    );

endmodule
